// ===== hw/rtl/ibmw_pkg.sv =====
// Shared constants, codes and queue entry type for the indirect block map walker.
package ibmw_pkg;

    // Geometry of the inode address table and of each indirect table
    localparam int DIRECT_COUNT = 10;
    localparam int INDEX_BITS   = 7;
    localparam int TABLE_SLOTS  = DIRECT_COUNT + 3;
    localparam int SLOT_W       = $clog2(TABLE_SLOTS);

    // Field widths
    localparam int WORD_W  = 32;
    localparam int WIDX_W  = 7;
    localparam int CMP_W   = WORD_W + 1;

    // Range boundaries, one bit wider than a block number
    localparam logic [CMP_W-1:0] BASE1 = CMP_W'(DIRECT_COUNT);
    localparam logic [CMP_W-1:0] BASE2 = BASE1 + (CMP_W'(1) << INDEX_BITS);
    localparam logic [CMP_W-1:0] BASE3 = BASE2 + (CMP_W'(1) << (2 * INDEX_BITS));
    localparam logic [CMP_W-1:0] LIMIT = BASE3 + (CMP_W'(1) << (3 * INDEX_BITS));

    localparam logic [WORD_W-1:0] IDX_MASK = WORD_W'((64'd1 << INDEX_BITS) - 64'd1);

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_MAP  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_MAPPED  = 2'd1;
    localparam logic [1:0] KIND_SEQ_ERR = 2'd2;
    localparam logic [1:0] KIND_RANGE   = 2'd3;

    // Classified operations carried through the queue
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_DIRECT = 3'd1;
    localparam logic [2:0] OP_WALK   = 3'd2;
    localparam logic [2:0] OP_RANGE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_BAD    = 3'd5;

    // Config register indexes
    localparam logic [0:0] REG_CANON_SWAP = 1'b0;

    // One classified request: data holds the slot address, the level offset,
    // the direct block number or the read word, depending on op
    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        levels;
        logic [3:0]        slot;
        logic [WORD_W-1:0] data;
    } t_item;

endpackage

// ===== hw/rtl/indirect_block_map_walker_unit.sv =====
// Top level of the indirect block map walker: config port, front end, queue, back end.
//
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_ready      action, slot, address, block, word
//  result    out        o_out_valid / i_out_ready    kind, block, word index, levels
//  config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One request is taken per cycle while the queue is not full; the edge that drains
// it from the two-entry queue also loads any result into the output register. The
// walk state and table are updated in order by the back end, one request per cycle
// while the result register is free or being taken. Reset is synchronous and clears
// the table, walk state, queue and result register. A stalled result backs up into
// the queue, and the request side stalls only when it is full.
module indirect_block_map_walker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_slot_address,
    input  logic [31:0] i_virtual_block,
    input  logic [31:0] i_read_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_block_number,
    output logic [6:0]  o_word_index,
    output logic [1:0]  o_levels_left,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_canon_swap;
    logic            cfg_write;
    ibmw_pkg::t_item front_item;
    ibmw_pkg::t_item head_item;
    logic            head_valid;
    logic            head_pop;

    // Config register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2:2] == ibmw_pkg::REG_CANON_SWAP);
    assign prdata    = (paddr[2:2] == ibmw_pkg::REG_CANON_SWAP) ? {31'd0, r_canon_swap}
                                                                 : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon_swap <= 1'b0;
        end else if (cfg_write) begin
            r_canon_swap <= pwdata[0];
        end
    end

    // Classify requests
    ibmw_front u_front (
        .i_action        (i_action),
        .i_slot_index    (i_slot_index),
        .i_slot_address  (i_slot_address),
        .i_virtual_block (i_virtual_block),
        .i_read_word     (i_read_word),
        .o_item          (front_item)
    );

    // Decouple front and back
    ibmw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_in_valid),
        .i_push_item  (front_item),
        .o_push_ready (o_in_ready),
        .i_pop        (head_pop),
        .o_head_valid (head_valid),
        .o_head_item  (head_item)
    );

    // Walk and answer
    ibmw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_canon_swap   (r_canon_swap),
        .i_head_valid   (head_valid),
        .i_head_item    (head_item),
        .o_pop          (head_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_block_number (o_block_number),
        .o_word_index   (o_word_index),
        .o_levels_left  (o_levels_left)
    );

endmodule

// ===== hw/rtl/ibmw_front.sv =====
// Front end: classify each incoming request into a queue entry.
module ibmw_front (
    input  logic [1:0]                 i_action,
    input  logic [3:0]                 i_slot_index,
    input  logic [ibmw_pkg::WORD_W-1:0] i_slot_address,
    input  logic [ibmw_pkg::WORD_W-1:0] i_virtual_block,
    input  logic [ibmw_pkg::WORD_W-1:0] i_read_word,
    output ibmw_pkg::t_item            o_item
);

    logic [ibmw_pkg::CMP_W-1:0] vb_ext;
    logic [ibmw_pkg::CMP_W-1:0] off1;
    logic [ibmw_pkg::CMP_W-1:0] off2;
    logic [ibmw_pkg::CMP_W-1:0] off3;

    // Offsets into each indirect range
    assign vb_ext = {1'b0, i_virtual_block};
    assign off1   = vb_ext - ibmw_pkg::BASE1;
    assign off2   = vb_ext - ibmw_pkg::BASE2;
    assign off3   = vb_ext - ibmw_pkg::BASE3;

    // Decode action and range class
    always_comb begin
        o_item.op     = ibmw_pkg::OP_BAD;
        o_item.levels = 2'd0;
        o_item.slot   = i_slot_index;
        o_item.data   = '0;
        case (i_action)
            ibmw_pkg::ACT_LOAD: begin
                o_item.op   = ibmw_pkg::OP_LOAD;
                o_item.data = i_slot_address;
            end
            ibmw_pkg::ACT_MAP: begin
                if (vb_ext < ibmw_pkg::BASE1) begin
                    o_item.op   = ibmw_pkg::OP_DIRECT;
                    o_item.data = i_virtual_block;
                end else if (vb_ext < ibmw_pkg::BASE2) begin
                    o_item.op     = ibmw_pkg::OP_WALK;
                    o_item.levels = 2'd1;
                    o_item.data   = off1[ibmw_pkg::WORD_W-1:0];
                end else if (vb_ext < ibmw_pkg::BASE3) begin
                    o_item.op     = ibmw_pkg::OP_WALK;
                    o_item.levels = 2'd2;
                    o_item.data   = off2[ibmw_pkg::WORD_W-1:0];
                end else if (vb_ext < ibmw_pkg::LIMIT) begin
                    o_item.op     = ibmw_pkg::OP_WALK;
                    o_item.levels = 2'd3;
                    o_item.data   = off3[ibmw_pkg::WORD_W-1:0];
                end else begin
                    o_item.op = ibmw_pkg::OP_RANGE;
                end
            end
            ibmw_pkg::ACT_READ: begin
                o_item.op   = ibmw_pkg::OP_READ;
                o_item.data = i_read_word;
            end
            default: begin
                o_item.op = ibmw_pkg::OP_BAD;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ibmw_queue.sv =====
// Short FIFO between the classifying front end and the walking back end.
module ibmw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ibmw_pkg::t_item i_push_item,
    output logic            o_push_ready,
    input  logic            i_pop,
    output logic            o_head_valid,
    output ibmw_pkg::t_item o_head_item
);

    ibmw_pkg::t_item                 r_mem [ibmw_pkg::QUEUE_DEPTH];
    logic [ibmw_pkg::QPTR_W-1:0]     r_wr;
    logic [ibmw_pkg::QPTR_W-1:0]     r_rd;
    logic [ibmw_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_push_ready = (r_cnt != ibmw_pkg::QCNT_W'(ibmw_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head_item  = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == ibmw_pkg::QPTR_W'(ibmw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == ibmw_pkg::QPTR_W'(ibmw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/ibmw_back.sv =====
// Back end: inode address table, walk state and registered result.
module ibmw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_canon_swap,
    input  logic                          i_head_valid,
    input  ibmw_pkg::t_item               i_head_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_result_kind,
    output logic [ibmw_pkg::WORD_W-1:0]   o_block_number,
    output logic [ibmw_pkg::WIDX_W-1:0]   o_word_index,
    output logic [1:0]                    o_levels_left
);

    logic [ibmw_pkg::WORD_W-1:0] r_table [ibmw_pkg::TABLE_SLOTS];
    logic [ibmw_pkg::WORD_W-1:0] r_offset;
    logic [1:0]                  r_plevels;
    logic                        r_busy;

    logic                        r_out_valid;
    logic [1:0]                  r_kind;
    logic [ibmw_pkg::WORD_W-1:0] r_block;
    logic [ibmw_pkg::WIDX_W-1:0] r_widx;
    logic [1:0]                  r_lleft;

    logic [ibmw_pkg::WORD_W-1:0] n_offset;
    logic [1:0]                  n_plevels;
    logic                        n_busy;

    logic                        res_valid;
    logic [1:0]                  res_kind;
    logic [ibmw_pkg::WORD_W-1:0] res_block;
    logic [ibmw_pkg::WIDX_W-1:0] res_widx;
    logic [1:0]                  res_lleft;

    logic [ibmw_pkg::SLOT_W-1:0] tbl_addr;
    logic [ibmw_pkg::WORD_W-1:0] tbl_data;
    logic [ibmw_pkg::WORD_W-1:0] rd_word;
    logic [ibmw_pkg::WORD_W-1:0] iss_off;
    logic [1:0]                  iss_lv;
    logic [ibmw_pkg::WORD_W-1:0] iss_shift;
    logic [ibmw_pkg::WORD_W-1:0] iss_idx;
    logic                        tbl_write;

    assign o_pop = i_head_valid && (!r_out_valid || i_out_ready);

    // Pick the table slot: direct block, or the root for this walk depth
    assign tbl_addr = (i_head_item.op == ibmw_pkg::OP_DIRECT)
                    ? i_head_item.data[ibmw_pkg::SLOT_W-1:0]
                    : ibmw_pkg::SLOT_W'(ibmw_pkg::DIRECT_COUNT - 1)
                      + ibmw_pkg::SLOT_W'(i_head_item.levels);
    assign tbl_data = r_table[tbl_addr];

    // Canonicalize a returned table word
    assign rd_word = i_canon_swap ? {i_head_item.data[15:0], i_head_item.data[31:16]}
                                  : i_head_item.data;

    // Word index for the next read: a new walk or a continuing one
    assign iss_off = (i_head_item.op == ibmw_pkg::OP_WALK) ? i_head_item.data : r_offset;
    assign iss_lv  = (i_head_item.op == ibmw_pkg::OP_WALK) ? i_head_item.levels : r_plevels;

    always_comb begin
        case (iss_lv)
            2'd2:    iss_shift = iss_off >> ibmw_pkg::INDEX_BITS;
            2'd3:    iss_shift = iss_off >> (2 * ibmw_pkg::INDEX_BITS);
            default: iss_shift = iss_off;
        endcase
    end

    assign iss_idx = iss_shift & ibmw_pkg::IDX_MASK;

    assign tbl_write = o_pop && (i_head_item.op == ibmw_pkg::OP_LOAD)
                     && (32'(i_head_item.slot) < 32'(ibmw_pkg::TABLE_SLOTS));

    // Execute the head request against the walk state
    always_comb begin
        n_offset  = r_offset;
        n_plevels = r_plevels;
        n_busy    = r_busy;
        res_valid = 1'b1;
        res_kind  = ibmw_pkg::KIND_SEQ_ERR;
        res_block = '0;
        res_widx  = '0;
        res_lleft = 2'd0;
        case (i_head_item.op)
            ibmw_pkg::OP_LOAD: begin
                res_valid = 1'b0;
            end
            ibmw_pkg::OP_DIRECT: begin
                if (!r_busy) begin
                    res_kind  = ibmw_pkg::KIND_MAPPED;
                    res_block = tbl_data;
                end
            end
            ibmw_pkg::OP_WALK: begin
                if (!r_busy) begin
                    n_offset  = i_head_item.data;
                    n_plevels = iss_lv - 2'd1;
                    n_busy    = 1'b1;
                    res_kind  = ibmw_pkg::KIND_READ;
                    res_block = tbl_data;
                    res_widx  = iss_idx[ibmw_pkg::WIDX_W-1:0];
                    res_lleft = iss_lv - 2'd1;
                end
            end
            ibmw_pkg::OP_RANGE: begin
                if (!r_busy) begin
                    res_kind = ibmw_pkg::KIND_RANGE;
                end
            end
            ibmw_pkg::OP_READ: begin
                if (r_busy) begin
                    if (r_plevels == 2'd0) begin
                        n_busy    = 1'b0;
                        res_kind  = ibmw_pkg::KIND_MAPPED;
                        res_block = rd_word;
                    end else begin
                        n_plevels = iss_lv - 2'd1;
                        res_kind  = ibmw_pkg::KIND_READ;
                        res_block = rd_word;
                        res_widx  = iss_idx[ibmw_pkg::WIDX_W-1:0];
                        res_lleft = iss_lv - 2'd1;
                    end
                end
            end
            default: begin
                res_kind = ibmw_pkg::KIND_SEQ_ERR;
            end
        endcase
    end

    // Update inode address table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ibmw_pkg::TABLE_SLOTS; i++) begin
                r_table[i] <= '0;
            end
        end else if (tbl_write) begin
            r_table[ibmw_pkg::SLOT_W'(i_head_item.slot)] <= i_head_item.data;
        end
    end

    // Advance walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_plevels <= 2'd0;
            r_busy    <= 1'b0;
        end else if (o_pop) begin
            r_offset  <= n_offset;
            r_plevels <= n_plevels;
            r_busy    <= n_busy;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_kind  <= res_kind;
            r_block <= res_block;
            r_widx  <= res_widx;
            r_lleft <= res_lleft;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_block_number = r_block;
    assign o_word_index   = r_widx;
    assign o_levels_left  = r_lleft;

endmodule
